FILE: rtl/core/weighted_tardiness_sequence_evaluator_macros.svh
// Assertion macros shared by the evaluator RTL.
`ifndef WEIGHTED_TARDINESS_SEQUENCE_EVALUATOR_MACROS_SVH
`define WEIGHTED_TARDINESS_SEQUENCE_EVALUATOR_MACROS_SVH

// Condition at an edge implies a consequence at the same edge.
`define WTSE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Condition at an edge implies a consequence at the following edge.
`define WTSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/wtse_pkg.sv
// Shared constants, types and helpers of the weighted tardiness evaluator.
package wtse_pkg;

  // Sizing of the job and setup stores
  localparam int MAX_JOBS    = 64;
  localparam int JOB_W       = $clog2(MAX_JOBS);
  localparam int SETUP_ROWS  = MAX_JOBS + 1;
  localparam int ROW_W       = $clog2(SETUP_ROWS);
  localparam int SETUP_AW    = ROW_W + JOB_W;
  localparam int SETUP_DEPTH = SETUP_ROWS * (2 ** JOB_W);

  // Request and result field widths
  localparam int OP_W    = 2;
  localparam int FROW_W  = 7;
  localparam int FJOB_W  = 6;
  localparam int SETUP_W = 16;
  localparam int PROC_W  = 16;
  localparam int DUE_W   = 24;
  localparam int WGT_W   = 16;
  localparam int POS_W   = 6;
  localparam int TIME_W  = 32;
  localparam int PEN_W   = 48;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [PEN_W-1:0]  PEN_MAX  = '1;

  typedef enum logic [OP_W-1:0] {
    OP_SETUP = 2'd0,
    OP_JOB   = 2'd1,
    OP_STEP  = 2'd2
  } op_e;

  // Per-job attributes as held in the job memory
  typedef struct packed {
    logic [PROC_W-1:0] proc;
    logic [DUE_W-1:0]  due;
    logic [WGT_W-1:0]  wgt;
  } job_attr_t;

  // Stored prefix of a sequence at one position
  typedef struct packed {
    logic [TIME_W-1:0] elapsed;
    logic [PEN_W-1:0]  pen;
    logic [FJOB_W-1:0] job;
  } prefix_t;

  // Request as it enters the evaluation pipe
  typedef struct packed {
    logic              step;
    logic              restart;
    logic              use_pre;
    logic              commit;
    logic              last;
    logic              setup_ok;
    logic              job_ok;
    logic              pos_ok;
    logic [FJOB_W-1:0] job;
    logic [POS_W-1:0]  pos;
    logic [TIME_W-1:0] pre_elapsed;
    logic [PEN_W-1:0]  pre_pen;
  } issue_t;

  // Request state carried through the later stages
  typedef struct packed {
    logic              step;
    logic              restart;
    logic              commit;
    logic              last;
    logic              pos_ok;
    logic [FJOB_W-1:0] job;
    logic [POS_W-1:0]  pos;
    logic [PEN_W-1:0]  pre_pen;
    logic [TIME_W-1:0] elapsed;
    logic              sat_t;
    logic [DUE_W-1:0]  due;
    logic [WGT_W-1:0]  wgt;
    logic [TIME_W-1:0] late;
    logic [PEN_W-1:0]  prod;
  } stage_t;

  // Result as delivered on the output channel
  typedef struct packed {
    logic [TIME_W-1:0] elapsed;
    logic [PEN_W-1:0]  pen;
    logic              total;
    logic              sat;
  } result_t;

  function automatic logic job_in_range(input logic [FJOB_W-1:0] j);
    return (int'(j) < MAX_JOBS);
  endfunction

  function automatic logic [JOB_W-1:0] job_addr(input logic [FJOB_W-1:0] j);
    return JOB_W'(j);
  endfunction

endpackage

FILE: rtl/core/wtse_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module wtse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and read, read data held while not enabled
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/wtse_issue.sv
// Request intake: handshake, prefix fetch interlock, memory addressing.
module wtse_issue (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [wtse_pkg::OP_W-1:0]        operation_i,
  input  logic [wtse_pkg::FROW_W-1:0]      from_row_i,
  input  logic [wtse_pkg::FJOB_W-1:0]      job_i,
  input  logic [wtse_pkg::SETUP_W-1:0]     setup_time_i,
  input  logic [wtse_pkg::PROC_W-1:0]      processing_time_i,
  input  logic [wtse_pkg::DUE_W-1:0]       due_date_i,
  input  logic [wtse_pkg::WGT_W-1:0]       weight_i,
  input  logic [wtse_pkg::POS_W-1:0]       position_i,
  input  logic                             restart_i,
  input  logic                             commit_i,
  input  logic                             is_last_i,
  input  logic                             pipe_en_i,
  input  logic                             commit_busy_i,
  input  wtse_pkg::prefix_t                pre_rdata_i,
  output logic                             setup_we_o,
  output logic [wtse_pkg::SETUP_AW-1:0]    setup_waddr_o,
  output logic [wtse_pkg::SETUP_W-1:0]     setup_wdata_o,
  output logic [wtse_pkg::SETUP_AW-1:0]    setup_raddr_o,
  output logic                             job_we_o,
  output logic [wtse_pkg::JOB_W-1:0]       job_waddr_o,
  output wtse_pkg::job_attr_t              job_wdata_o,
  output logic [wtse_pkg::JOB_W-1:0]       job_raddr_o,
  output logic [wtse_pkg::JOB_W-1:0]       pre_raddr_o,
  output logic                             accept_o,
  output wtse_pkg::issue_t                 item_o
);
  import wtse_pkg::*;

  logic              is_step;
  logic              need_pre;
  logic              accept;
  logic              fetched_q, fetched_d;
  logic [FROW_W-1:0] prev_row_q, prev_row_d;
  logic [FROW_W-1:0] row_sel;

  // Decode the request
  assign is_step  = (operation_i == OP_STEP);
  assign need_pre = is_step && restart_i && (position_i != '0)
                    && ((int'(position_i) - 1) < MAX_JOBS);

  // Hold a prefix resume until its prefix read is done and no commit is in flight
  assign in_stall_o = !pipe_en_i || (need_pre && (commit_busy_i || !fetched_q));
  assign accept     = in_valid_i && !in_stall_o;
  assign accept_o   = accept;
  assign fetched_d  = in_valid_i && need_pre && !commit_busy_i && !accept;

  // Pick the setup row this step leaves from
  always_comb begin
    row_sel = prev_row_q;
    if (restart_i) begin
      if (need_pre) begin
        row_sel = FROW_W'(pre_rdata_i.job) + FROW_W'(1);
      end else begin
        row_sel = '0;
      end
    end
  end

  // Track the row that follows the last accepted step
  always_comb begin
    prev_row_d = prev_row_q;
    if (accept && is_step) begin
      prev_row_d = is_last_i ? '0 : FROW_W'(job_i) + FROW_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fetched_q  <= 1'b0;
      prev_row_q <= '0;
    end else begin
      fetched_q  <= fetched_d;
      prev_row_q <= prev_row_d;
    end
  end

  // Drive table writes and reads
  assign setup_we_o    = accept && (operation_i == OP_SETUP)
                         && (int'(from_row_i) < SETUP_ROWS) && job_in_range(job_i);
  assign setup_waddr_o = {ROW_W'(from_row_i), job_addr(job_i)};
  assign setup_wdata_o = setup_time_i;
  assign setup_raddr_o = {ROW_W'(row_sel), job_addr(job_i)};

  assign job_we_o          = accept && (operation_i == OP_JOB) && job_in_range(job_i);
  assign job_waddr_o       = job_addr(job_i);
  assign job_wdata_o.proc  = processing_time_i;
  assign job_wdata_o.due   = due_date_i;
  assign job_wdata_o.wgt   = weight_i;
  assign job_raddr_o       = job_addr(job_i);

  assign pre_raddr_o = job_addr(position_i - POS_W'(1));

  // Build the pipe entry
  always_comb begin
    item_o.step        = is_step;
    item_o.restart     = restart_i;
    item_o.use_pre     = need_pre;
    item_o.commit      = commit_i;
    item_o.last        = is_last_i;
    item_o.setup_ok    = (int'(row_sel) < SETUP_ROWS) && job_in_range(job_i);
    item_o.job_ok      = job_in_range(job_i);
    item_o.pos_ok      = int'(position_i) < MAX_JOBS;
    item_o.job         = job_i;
    item_o.pos         = position_i;
    item_o.pre_elapsed = need_pre ? pre_rdata_i.elapsed : '0;
    item_o.pre_pen     = need_pre ? pre_rdata_i.pen : '0;
  end

endmodule

FILE: rtl/core/wtse_eval.sv
// Four-stage evaluation pipe: time sum, lateness, weighting, penalty sum.
module wtse_eval (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           pipe_en_i,
  input  logic                           accept_i,
  input  wtse_pkg::issue_t               item_i,
  input  logic [wtse_pkg::SETUP_W-1:0]   setup_rdata_i,
  input  wtse_pkg::job_attr_t            job_rdata_i,
  output logic                           commit_busy_o,
  output logic                           pre_we_o,
  output logic [wtse_pkg::JOB_W-1:0]     pre_waddr_o,
  output wtse_pkg::prefix_t              pre_wdata_o,
  output logic                           res_valid_o,
  output wtse_pkg::result_t              res_o
);
  import wtse_pkg::*;

  logic s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q;
  issue_t s1_q;
  stage_t s2_q, s3_q, s4_q;
  stage_t s2_d, s3_d, s4_d;

  logic [TIME_W-1:0]  run_time_q, run_time_d;
  logic [PEN_W-1:0]   run_pen_q, run_pen_d;
  logic [SETUP_W-1:0] setup_v;
  job_attr_t          attr_v;
  logic [TIME_W-1:0]  t_base;
  logic [TIME_W:0]    t_sum;
  logic [PEN_W-1:0]   p_base;
  logic [PEN_W:0]     p_sum;
  logic [PEN_W-1:0]   p_new;
  logic               p_sat;

  // Stage 1: add setup and processing time to the running or resumed time
  always_comb begin
    setup_v = s1_q.setup_ok ? setup_rdata_i : '0;
    attr_v  = s1_q.job_ok ? job_rdata_i : '0;
    t_base  = s1_q.restart ? s1_q.pre_elapsed : run_time_q;
    t_sum   = (TIME_W+1)'(t_base) + (TIME_W+1)'(setup_v) + (TIME_W+1)'(attr_v.proc);

    s2_d         = '0;
    s2_d.step    = s1_q.step;
    s2_d.restart = s1_q.restart;
    s2_d.commit  = s1_q.commit;
    s2_d.last    = s1_q.last;
    s2_d.pos_ok  = s1_q.pos_ok;
    s2_d.job     = s1_q.job;
    s2_d.pos     = s1_q.pos;
    s2_d.pre_pen = s1_q.pre_pen;
    s2_d.sat_t   = t_sum[TIME_W];
    s2_d.elapsed = t_sum[TIME_W] ? TIME_MAX : t_sum[TIME_W-1:0];
    s2_d.due     = attr_v.due;
    s2_d.wgt     = attr_v.wgt;

    run_time_d = run_time_q;
    if (pipe_en_i && s1_vld_q && s1_q.step) begin
      run_time_d = s1_q.last ? '0 : s2_d.elapsed;
    end
  end

  // Stage 2: lateness past the due date
  always_comb begin
    s3_d      = s2_q;
    s3_d.late = (s2_q.elapsed > TIME_W'(s2_q.due)) ? s2_q.elapsed - TIME_W'(s2_q.due) : '0;
  end

  // Stage 3: weight the lateness
  always_comb begin
    s4_d      = s3_q;
    s4_d.prod = PEN_W'(s3_q.late) * PEN_W'(s3_q.wgt);
  end

  // Stage 4: accumulate the penalty, clip at its maximum
  always_comb begin
    p_base = s4_q.restart ? s4_q.pre_pen : run_pen_q;
    p_sum  = (PEN_W+1)'(p_base) + (PEN_W+1)'(s4_q.prod);
    p_sat  = p_sum[PEN_W];
    p_new  = p_sat ? PEN_MAX : p_sum[PEN_W-1:0];

    run_pen_d = run_pen_q;
    if (pipe_en_i && s4_vld_q && s4_q.step) begin
      run_pen_d = s4_q.last ? '0 : p_new;
    end
  end

  // Store the prefix at the requested position
  assign pre_we_o            = pipe_en_i && s4_vld_q && s4_q.step && s4_q.commit && s4_q.pos_ok;
  assign pre_waddr_o         = job_addr(s4_q.pos);
  assign pre_wdata_o.elapsed = s4_q.elapsed;
  assign pre_wdata_o.pen     = p_new;
  assign pre_wdata_o.job     = s4_q.job;

  // Present the result, zero for write requests
  assign res_valid_o   = s4_vld_q;
  assign res_o.elapsed = s4_q.step ? s4_q.elapsed : '0;
  assign res_o.pen     = s4_q.step ? p_new : '0;
  assign res_o.total   = s4_q.step && s4_q.last;
  assign res_o.sat     = s4_q.step && (s4_q.sat_t || p_sat);

  // Flag any committing step still ahead of its prefix write
  assign commit_busy_o = (s1_vld_q && s1_q.step && s1_q.commit)
                      || (s2_vld_q && s2_q.step && s2_q.commit)
                      || (s3_vld_q && s3_q.step && s3_q.commit)
                      || (s4_vld_q && s4_q.step && s4_q.commit);

  // Advance valid flags and running sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q   <= 1'b0;
      s2_vld_q   <= 1'b0;
      s3_vld_q   <= 1'b0;
      s4_vld_q   <= 1'b0;
      run_time_q <= '0;
      run_pen_q  <= '0;
    end else begin
      if (pipe_en_i) begin
        s1_vld_q <= accept_i;
        s2_vld_q <= s1_vld_q;
        s3_vld_q <= s2_vld_q;
        s4_vld_q <= s3_vld_q;
      end
      run_time_q <= run_time_d;
      run_pen_q  <= run_pen_d;
    end
  end

  // Advance stage payloads
  always_ff @(posedge clk_i) begin
    if (pipe_en_i) begin
      s1_q <= item_i;
      s2_q <= s2_d;
      s3_q <= s3_d;
      s4_q <= s4_d;
    end
  end

endmodule

FILE: rtl/core/wtse_outbuf.sv
// Output register with one skid entry between the pipe and the result channel.
module wtse_outbuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  wtse_pkg::result_t res_i,
  input  logic              out_stall_i,
  output logic              pipe_en_o,
  output logic              out_valid_o,
  output wtse_pkg::result_t out_res_o
);
  import wtse_pkg::*;

  logic    out_vld_q, out_vld_d;
  logic    skid_vld_q, skid_vld_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    take;

  assign pipe_en_o   = !skid_vld_q;
  assign take        = out_vld_q && !out_stall_i;
  assign out_valid_o = out_vld_q;
  assign out_res_o   = out_q;

  // Refill from skid first, else park a new result where there is room
  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    out_d      = out_q;
    skid_d     = skid_q;
    priority if (skid_vld_q) begin
      if (take) begin
        out_d      = skid_q;
        skid_vld_d = 1'b0;
      end
    end else if (push_i) begin
      if (out_vld_q && !take) begin
        skid_d     = res_i;
        skid_vld_d = 1'b1;
      end else begin
        out_d     = res_i;
        out_vld_d = 1'b1;
      end
    end else if (take) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

endmodule

FILE: rtl/core/weighted_tardiness_sequence_evaluator.sv
// Top level of the weighted tardiness sequence evaluator.
// Path: an accepted request passes stage registers s1 to s4, then the output register.
// Throughput: one request per cycle while the output buffer does not push back; a step resuming
// from a stored prefix is held for the prefix memory read, and while committing steps are in the pipe.
// Reset: clears running time, penalty, setup row and valid flags; memories are not cleared.
`include "weighted_tardiness_sequence_evaluator_macros.svh"

module weighted_tardiness_sequence_evaluator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [wtse_pkg::OP_W-1:0]    operation_i,
  input  logic [wtse_pkg::FROW_W-1:0]  from_row_i,
  input  logic [wtse_pkg::FJOB_W-1:0]  job_i,
  input  logic [wtse_pkg::SETUP_W-1:0] setup_time_i,
  input  logic [wtse_pkg::PROC_W-1:0]  processing_time_i,
  input  logic [wtse_pkg::DUE_W-1:0]   due_date_i,
  input  logic [wtse_pkg::WGT_W-1:0]   weight_i,
  input  logic [wtse_pkg::POS_W-1:0]   position_i,
  input  logic                         restart_i,
  input  logic                         commit_i,
  input  logic                         is_last_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [wtse_pkg::TIME_W-1:0]  elapsed_time_o,
  output logic [wtse_pkg::PEN_W-1:0]   penalty_o,
  output logic                         sequence_total_o,
  output logic                         saturated_o
);
  import wtse_pkg::*;

  logic                setup_we;
  logic [SETUP_AW-1:0] setup_waddr, setup_raddr;
  logic [SETUP_W-1:0]  setup_wdata, setup_rdata;
  logic                job_we;
  logic [JOB_W-1:0]    job_waddr, job_raddr;
  job_attr_t           job_wdata, job_rdata;
  logic                pre_we;
  logic [JOB_W-1:0]    pre_waddr, pre_raddr;
  prefix_t             pre_wdata, pre_rdata;
  logic                pipe_en;
  logic                commit_busy;
  logic                accept;
  issue_t              item;
  logic                res_valid;
  result_t             res;
  result_t             out_res;

  // Intake
  wtse_issue u_issue (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .operation_i       (operation_i),
    .from_row_i        (from_row_i),
    .job_i             (job_i),
    .setup_time_i      (setup_time_i),
    .processing_time_i (processing_time_i),
    .due_date_i        (due_date_i),
    .weight_i          (weight_i),
    .position_i        (position_i),
    .restart_i         (restart_i),
    .commit_i          (commit_i),
    .is_last_i         (is_last_i),
    .pipe_en_i         (pipe_en),
    .commit_busy_i     (commit_busy),
    .pre_rdata_i       (pre_rdata),
    .setup_we_o        (setup_we),
    .setup_waddr_o     (setup_waddr),
    .setup_wdata_o     (setup_wdata),
    .setup_raddr_o     (setup_raddr),
    .job_we_o          (job_we),
    .job_waddr_o       (job_waddr),
    .job_wdata_o       (job_wdata),
    .job_raddr_o       (job_raddr),
    .pre_raddr_o       (pre_raddr),
    .accept_o          (accept),
    .item_o            (item)
  );

  // Setup table, one row per leaving state
  wtse_ram #(
    .WIDTH (SETUP_W),
    .DEPTH (SETUP_DEPTH)
  ) u_setup_ram (
    .clk_i   (clk_i),
    .we_i    (setup_we),
    .waddr_i (setup_waddr),
    .wdata_i (setup_wdata),
    .re_i    (pipe_en),
    .raddr_i (setup_raddr),
    .rdata_o (setup_rdata)
  );

  // Job attributes
  wtse_ram #(
    .WIDTH ($bits(job_attr_t)),
    .DEPTH (MAX_JOBS)
  ) u_job_ram (
    .clk_i   (clk_i),
    .we_i    (job_we),
    .waddr_i (job_waddr),
    .wdata_i (job_wdata),
    .re_i    (pipe_en),
    .raddr_i (job_raddr),
    .rdata_o (job_rdata)
  );

  // Stored prefixes
  wtse_ram #(
    .WIDTH ($bits(prefix_t)),
    .DEPTH (MAX_JOBS)
  ) u_prefix_ram (
    .clk_i   (clk_i),
    .we_i    (pre_we),
    .waddr_i (pre_waddr),
    .wdata_i (pre_wdata),
    .re_i    (1'b1),
    .raddr_i (pre_raddr),
    .rdata_o (pre_rdata)
  );

  // Evaluation pipe
  wtse_eval u_eval (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pipe_en_i     (pipe_en),
    .accept_i      (accept),
    .item_i        (item),
    .setup_rdata_i (setup_rdata),
    .job_rdata_i   (job_rdata),
    .commit_busy_o (commit_busy),
    .pre_we_o      (pre_we),
    .pre_waddr_o   (pre_waddr),
    .pre_wdata_o   (pre_wdata),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  // Result buffering
  wtse_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .res_i       (res),
    .out_stall_i (out_stall_i),
    .pipe_en_o   (pipe_en),
    .out_valid_o (out_valid_o),
    .out_res_o   (out_res)
  );

  assign elapsed_time_o   = out_res.elapsed;
  assign penalty_o        = out_res.pen;
  assign sequence_total_o = out_res.total;
  assign saturated_o      = out_res.sat;

  // A resumed step never overlaps a pending prefix write
  `WTSE_ASSERT_NOW(a_resume_no_commit, accept && item.use_pre, !commit_busy, "resume raced a commit")
  // A resumed step was held for its prefix read in the cycle before
  `WTSE_ASSERT_NOW(a_resume_fetched, accept && item.use_pre, $past(in_valid_i && in_stall_o), "resume without prefix read")
  // A full skid entry implies a result waiting at the output
  `WTSE_ASSERT_NOW(a_skid_behind_out, !pipe_en, out_valid_o, "skid full with empty output")
  // A result leaving the pipe shows up at the output
  `WTSE_ASSERT_NEXT(a_push_shows, pipe_en && res_valid, out_valid_o, "result lost after pipe")

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the weighted tardiness sequence evaluator.
module tb_top;
  import wtse_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS  = 1000;
  localparam int SAT_CHAIN_LEN = 300;  // long enough to clip the penalty
  localparam int HOLDOFF_AT    = 150;
  localparam int HOLDOFF_LEN   = 400;
  localparam int IDLE_LIMIT    = 2000;
  localparam int DRAIN_CYCLES  = 20;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [FROW_W-1:0]  row;
    logic [FJOB_W-1:0]  job;
    logic [SETUP_W-1:0] setup;
    logic [PROC_W-1:0]  proc;
    logic [DUE_W-1:0]   due;
    logic [WGT_W-1:0]   wgt;
    logic [POS_W-1:0]   pos;
    logic               restart;
    logic               commit;
    logic               last;
  } request_t;

  // Clock, reset and block ports
  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [OP_W-1:0]    operation = '0;
  logic [FROW_W-1:0]  from_row = '0;
  logic [FJOB_W-1:0]  job = '0;
  logic [SETUP_W-1:0] setup_time = '0;
  logic [PROC_W-1:0]  processing_time = '0;
  logic [DUE_W-1:0]   due_date = '0;
  logic [WGT_W-1:0]   weight = '0;
  logic [POS_W-1:0]   position = '0;
  logic               restart = 1'b0;
  logic               commit = 1'b0;
  logic               is_last = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [TIME_W-1:0]  elapsed_time;
  logic [PEN_W-1:0]   penalty;
  logic               sequence_total;
  logic               saturated;

  // Shadow of the evaluator state
  logic [SETUP_W-1:0] setup_mem [SETUP_ROWS][MAX_JOBS];
  job_attr_t          job_mem [MAX_JOBS];
  prefix_t            prefix_mem [MAX_JOBS];
  logic [TIME_W-1:0]  run_elapsed = '0;
  logic [PEN_W-1:0]   run_penalty = '0;
  logic [FROW_W-1:0]  run_row = '0;

  // Stimulus planning and bookkeeping
  request_t pending_requests[$];
  result_t  expected_costs[$];
  request_t cur_request;
  int       pool[$];
  bit       plan_prefix_ok [MAX_JOBS];
  int       effective_items = 0;
  int       requests_sent = 0;
  int       steps_sent = 0;
  int       results_checked = 0;
  int       saturated_seen = 0;
  int       cost_errors = 0;
  int       gap_left = 0;
  int       stall_left = 0;
  int       holdoff_left = 0;
  int       idle_cycles = 0;
  bit       send_calm = 1'b0;
  bit       recv_calm = 1'b0;

  weighted_tardiness_sequence_evaluator DUT (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .operation_i      (operation),
    .from_row_i       (from_row),
    .job_i            (job),
    .setup_time_i     (setup_time),
    .processing_time_i(processing_time),
    .due_date_i       (due_date),
    .weight_i         (weight),
    .position_i       (position),
    .restart_i        (restart),
    .commit_i         (commit),
    .is_last_i        (is_last),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .elapsed_time_o   (elapsed_time),
    .penalty_o        (penalty),
    .sequence_total_o (sequence_total),
    .saturated_o      (saturated)
  );

  always #5 clk = ~clk;

  // Apply one request to the shadow state and return the result it yields
  function automatic result_t evaluate_tardiness(input request_t rq);
    result_t    res;
    logic [63:0] t;
    logic [63:0] p;
    logic [FROW_W-1:0] prev;
    job_attr_t   attr;
    res = '0;
    case (rq.op)
      OP_SETUP: begin
        if (int'(rq.row) < SETUP_ROWS) setup_mem[rq.row][rq.job] = rq.setup;
      end
      OP_JOB: begin
        job_mem[rq.job] = '{proc: rq.proc, due: rq.due, wgt: rq.wgt};
      end
      OP_STEP: begin
        t = 64'(run_elapsed);
        p = 64'(run_penalty);
        prev = run_row;
        // resume from the prefix stored one position back
        if (rq.restart) begin
          t = '0;
          p = '0;
          prev = '0;
          if (rq.pos != '0) begin
            t = 64'(prefix_mem[rq.pos - POS_W'(1)].elapsed);
            p = 64'(prefix_mem[rq.pos - POS_W'(1)].pen);
            prev = FROW_W'(prefix_mem[rq.pos - POS_W'(1)].job) + FROW_W'(1);
          end
        end
        attr = job_mem[rq.job];
        t = t + 64'(setup_mem[prev][rq.job]) + 64'(attr.proc);
        if (t > 64'(TIME_MAX)) begin
          t = 64'(TIME_MAX);
          res.sat = 1'b1;
        end
        if (t > 64'(attr.due)) begin
          p = p + (t - 64'(attr.due)) * 64'(attr.wgt);
          if (p > 64'(PEN_MAX)) begin
            p = 64'(PEN_MAX);
            res.sat = 1'b1;
          end
        end
        if (rq.commit) begin
          prefix_mem[rq.pos] = '{elapsed: t[TIME_W-1:0], pen: p[PEN_W-1:0], job: rq.job};
        end
        // end of sequence drops back to the initial state
        if (rq.last) begin
          run_elapsed = '0;
          run_penalty = '0;
          run_row = '0;
        end else begin
          run_elapsed = t[TIME_W-1:0];
          run_penalty = p[PEN_W-1:0];
          run_row = FROW_W'(rq.job) + FROW_W'(1);
        end
        res.elapsed = t[TIME_W-1:0];
        res.pen = p[PEN_W-1:0];
        res.total = rq.last;
      end
      default: ;
    endcase
    return res;
  endfunction

  // Wait draw per request; calm stretches give back-to-back transfers
  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 31) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic request_t random_request();
    return request_t'({$urandom, $urandom, $urandom});
  endfunction

  function automatic logic [FJOB_W-1:0] pick_job();
    return FJOB_W'(pool[$urandom_range(0, pool.size() - 1)]);
  endfunction

  function automatic logic [PROC_W-1:0] rand_duration();
    return ($urandom_range(0, 3) == 0) ? PROC_W'($urandom) : PROC_W'($urandom_range(0, 3000));
  endfunction

  function automatic logic [DUE_W-1:0] rand_due();
    case ($urandom_range(0, 3))
      0: return DUE_W'($urandom);
      1: return '0;
      default: return DUE_W'($urandom_range(0, 40000));
    endcase
  endfunction

  function automatic logic [WGT_W-1:0] rand_weight();
    return ($urandom_range(0, 7) == 0) ? '0 : WGT_W'($urandom);
  endfunction

  task automatic push_request(input request_t rq);
    pending_requests.push_back(rq);
    if (rq.op != OP_UNUSED && !(rq.op == OP_SETUP && int'(rq.row) >= SETUP_ROWS)) begin
      effective_items++;
    end
  endtask

  task automatic add_setup(input logic [FROW_W-1:0] row, input logic [FJOB_W-1:0] jb,
                           input logic [SETUP_W-1:0] value);
    request_t rq;
    rq = random_request();
    rq.op = OP_SETUP;
    rq.row = row;
    rq.job = jb;
    rq.setup = value;
    push_request(rq);
  endtask

  task automatic add_job(input logic [FJOB_W-1:0] jb, input logic [PROC_W-1:0] proc,
                         input logic [DUE_W-1:0] due, input logic [WGT_W-1:0] wgt);
    request_t rq;
    rq = random_request();
    rq.op = OP_JOB;
    rq.job = jb;
    rq.proc = proc;
    rq.due = due;
    rq.wgt = wgt;
    push_request(rq);
  endtask

  task automatic add_unused_op();
    request_t rq;
    rq = random_request();
    rq.op = OP_UNUSED;
    push_request(rq);
  endtask

  // Steps only use pool jobs, so every setup they read has been loaded
  task automatic add_step(input logic [FJOB_W-1:0] jb, input int pos, input bit rs,
                          input bit cm, input bit lst);
    request_t rq;
    rq = random_request();
    if (rs && pos != 0 && !plan_prefix_ok[pos - 1]) rs = 1'b0;
    rq.op = OP_STEP;
    rq.job = jb;
    rq.pos = POS_W'(pos);
    rq.restart = rs;
    rq.commit = cm;
    rq.last = lst;
    if (cm) plan_prefix_ok[pos] = 1'b1;
    push_request(rq);
  endtask

  task present_request();
    cur_request = pending_requests.pop_front();
    in_valid        <= 1'b1;
    operation       <= cur_request.op;
    from_row        <= cur_request.row;
    job             <= cur_request.job;
    setup_time      <= cur_request.setup;
    processing_time <= cur_request.proc;
    due_date        <= cur_request.due;
    weight          <= cur_request.wgt;
    position        <= cur_request.pos;
    restart         <= cur_request.restart;
    commit          <= cur_request.commit;
    is_last         <= cur_request.last;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      cost_errors++;
    end
  endtask

  // Driver: offer the next request after its drawn gap; predict on acceptance
  always @(posedge clk or negedge rst_n) begin
    int gap;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (in_valid && !in_stall) begin
      expected_costs.push_back(evaluate_tardiness(cur_request));
      requests_sent++;
      if (cur_request.op == OP_STEP) steps_sent++;
      gap = draw_wait(send_calm);
      if (gap == 0 && pending_requests.size() != 0) begin
        present_request();
      end else begin
        in_valid <= 1'b0;
        gap_left <= (gap > 0) ? gap - 1 : 0;
      end
    end else if (!in_valid) begin
      if (gap_left > 0) gap_left <= gap_left - 1;
      else if (pending_requests.size() != 0) present_request();
    end
  end

  // Monitor: check each result against the oldest prediction, then stall
  always @(posedge clk or negedge rst_n) begin
    result_t want;
    int      stall_next;
    int      hold_next;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
      holdoff_left <= 0;
    end else begin
      stall_next = (stall_left > 0) ? stall_left - 1 : 0;
      hold_next = (holdoff_left > 0) ? holdoff_left - 1 : 0;
      if (out_valid && !out_stall) begin
        if (expected_costs.size() == 0) begin
          $error("result with no request outstanding: elapsed_time %0d penalty %0d",
                 elapsed_time, penalty);
          cost_errors++;
        end else begin
          want = expected_costs.pop_front();
          check_field("elapsed_time", 64'(want.elapsed), 64'(elapsed_time));
          check_field("penalty", 64'(want.pen), 64'(penalty));
          check_field("sequence_total", 64'(want.total), 64'(sequence_total));
          check_field("saturated", 64'(want.sat), 64'(saturated));
        end
        results_checked++;
        if (saturated) saturated_seen++;
        // long hold-off so the pipe fills and pushes back on the input
        if (results_checked == HOLDOFF_AT) hold_next = HOLDOFF_LEN;
        stall_next = draw_wait(recv_calm);
      end
      stall_left <= stall_next;
      holdoff_left <= hold_next;
      out_stall <= (stall_next != 0) || (hold_next != 0);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("Timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int rows[$];
    int cand;
    int start_count;
    int choice;
    int len;
    int k;
    bit found;

    // Job pool covers every bit of the job index
    pool = '{0, 1, 2, 4, 8, 16, 32, 63};
    while (pool.size() < 10) begin
      cand = $urandom_range(0, 63);
      found = 1'b0;
      foreach (pool[i]) if (pool[i] == cand) found = 1'b1;
      if (!found) pool.push_back(cand);
    end

    // Load attributes and every setup reachable from the pool
    foreach (pool[i]) add_job(FJOB_W'(pool[i]), rand_duration(), rand_due(), rand_weight());
    rows.push_back(0);
    foreach (pool[i]) rows.push_back(pool[i] + 1);
    foreach (rows[r]) begin
      foreach (pool[c]) add_setup(FROW_W'(rows[r]), FJOB_W'(pool[c]), rand_duration());
    end

    // Directed: field extremes, ignored writes, unused code, resume and end of sequence
    add_job(0, '0, '1, '1);
    add_job(1, '1, '0, '0);
    add_job(63, '1, '0, '1);
    add_setup(0, 0, '0);
    add_setup(64, 63, '1);
    add_setup(127, 5, rand_duration());
    add_setup(FROW_W'(SETUP_ROWS), 0, rand_duration());
    add_unused_op();
    add_step(0, 0, 1'b1, 1'b1, 1'b0);
    add_step(63, 1, 1'b0, 1'b1, 1'b0);
    add_step(1, 2, 1'b0, 1'b1, 1'b1);
    add_step(2, 2, 1'b1, 1'b0, 1'b1);
    add_step(63, 1, 1'b1, 1'b1, 1'b0);
    add_step(0, 2, 1'b0, 1'b0, 1'b1);
    add_step(4, 0, 1'b0, 1'b0, 1'b1);

    // One long late sequence: the penalty clips at its maximum
    add_job(63, '1, '0, '1);
    add_setup(0, 63, '1);
    add_setup(64, 63, '1);
    for (int i = 0; i < SAT_CHAIN_LEN; i++) begin
      add_step(63, $urandom_range(0, 63), i == 0, 1'b0, i == SAT_CHAIN_LEN - 1);
    end

    // Random: mostly whole sequences and moves on them, some loose traffic
    start_count = effective_items;
    while (effective_items - start_count < RANDOM_ITEMS) begin
      choice = $urandom_range(0, 99);
      if (choice < 50) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
          add_step(pick_job(), i, i == 0, $urandom_range(0, 9) != 0, i == len - 1);
        end
      end else if (choice < 75) begin
        // re-evaluate a tail after a stored position
        k = $urandom_range(0, 63);
        if (k > 0 && !plan_prefix_ok[k - 1]) k = 0;
        len = $urandom_range(1, 8);
        if (k + len > MAX_JOBS) len = MAX_JOBS - k;
        for (int i = 0; i < len; i++) begin
          add_step(pick_job(), k + i, i == 0, $urandom_range(0, 1) != 0, i == len - 1);
        end
      end else if (choice < 84) begin
        add_setup(FROW_W'(($urandom_range(0, 1) != 0) ? rows[$urandom_range(0, rows.size() - 1)]
                                                       : $urandom_range(0, 127)),
                  ($urandom_range(0, 1) != 0) ? pick_job() : FJOB_W'($urandom_range(0, 63)),
                  rand_duration());
      end else if (choice < 90) begin
        add_job(FJOB_W'($urandom_range(0, 63)), rand_duration(), rand_due(), rand_weight());
      end else if (choice < 93) begin
        add_unused_op();
      end else begin
        add_step(pick_job(), $urandom_range(0, 63), $urandom_range(0, 1) != 0,
                 $urandom_range(0, 1) != 0, $urandom_range(0, 1) != 0);
      end
    end

    // Reset, then run until every prediction has been matched
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_requests.size() != 0 || in_valid || expected_costs.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests, %0d of them schedule steps incl. a %0d-step clipping run",
             requests_sent, steps_sent, SAT_CHAIN_LEN);
    $display("Checked %0d results, %0d saturated, %0d mismatches",
             results_checked, saturated_seen, cost_errors);
    if (cost_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
